// ===== rtl/core/dtw_pkg.sv =====
// Shared types and constants for the depth triangle warp block.
// Used by dtw_ctrl, dtw_dp and depth_triangle_warp_max; depends on nothing.
`timescale 1ns / 1ps

package dtw_pkg;

    localparam int FRAME_W = 64;
    localparam int FRAME_H = 64;
    localparam int EDGE    = 4;
    localparam int STORE_W = FRAME_W + 2 * EDGE;
    localparam int STORE_H = FRAME_H + 2 * EDGE;
    localparam int STORE_N = STORE_W * STORE_H;
    localparam int AW      = $clog2(STORE_N);

    // Datapath widths: corner positions, edge deltas, multiplier operands,
    // product, accumulator, box coordinates, divider remainder and divisor.
    localparam int VW   = 21;
    localparam int DW   = 23;
    localparam int MW   = 26;
    localparam int PW   = 2 * MW;
    localparam int ACCW = 48;
    localparam int BW   = 15;
    localparam int RW   = 42;
    localparam int DSW  = 40;

    localparam logic [15:0] EMPTY_DEPTH = 16'h8000;
    localparam logic [12:0] RAISED_MAX  = 13'h1FFF;

    localparam logic [1:0] OP_SPLAT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DISP_X       = 3'd2;
    localparam logic [2:0] CFG_DISP_Y       = 3'd3;
    localparam logic [2:0] CFG_AREA_LIMIT   = 3'd4;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_LOAD, CMD_CLR, CMD_SMUL, CMD_SWR, CMD_TRI,
        CMD_A1, CMD_A2, CMD_A3, CMD_PD,
        CMD_E1, CMD_E2, CMD_E3, CMD_E4, CMD_E5, CMD_E6,
        CMD_N1, CMD_N2, CMD_N3, CMD_N4,
        CMD_DINIT, CMD_DIV, CMD_WR, CMD_NEXT,
        CMD_READ, CMD_CLEAR, CMD_FIN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [3:0] idx;
        logic       tri_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       area_skip;
        logic       box_empty;
        logic       covered;
        logic       last_x;
        logic       last_y;
        logic       clr_last;
        logic       out_busy;
    } dp_status_t;

endpackage

// ===== rtl/core/dtw_ctrl.sv =====
// Sequencer for the depth triangle warp block: issues one datapath command per cycle.
// Depends on dtw_pkg.
`timescale 1ns / 1ps

module dtw_ctrl
    import dtw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [27:0] {
        ST_CLR   = 28'h0000001,
        ST_IDLE  = 28'h0000002,
        ST_SMUL  = 28'h0000004,
        ST_SWR   = 28'h0000008,
        ST_TRI   = 28'h0000010,
        ST_A1    = 28'h0000020,
        ST_A2    = 28'h0000040,
        ST_A3    = 28'h0000080,
        ST_TCHK  = 28'h0000100,
        ST_PD    = 28'h0000200,
        ST_E1    = 28'h0000400,
        ST_E2    = 28'h0000800,
        ST_E3    = 28'h0001000,
        ST_E4    = 28'h0002000,
        ST_E5    = 28'h0004000,
        ST_E6    = 28'h0008000,
        ST_CHK   = 28'h0010000,
        ST_N1    = 28'h0020000,
        ST_N2    = 28'h0040000,
        ST_N3    = 28'h0080000,
        ST_N4    = 28'h0100000,
        ST_DINIT = 28'h0200000,
        ST_DIV   = 28'h0400000,
        ST_WR    = 28'h0800000,
        ST_NEXT  = 28'h1000000,
        ST_READ  = 28'h2000000,
        ST_CLEAR = 28'h4000000,
        ST_FIN   = 28'h8000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       tri_reg, tri_next;

    assign in_ready    = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            step_reg  <= 4'd0;
            tri_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            tri_reg   <= tri_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        tri_next    = tri_reg;
        cmd.op      = CMD_NOP;
        cmd.idx     = step_reg;
        cmd.tri_sel = tri_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.op = CMD_CLR;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    step_next  = 4'd0;
                    tri_next   = 1'b0;
                    state_next = ST_FIN;
                    case (status.opcode)
                        OP_SPLAT: state_next = ST_SMUL;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_SMUL:
            begin
                cmd.op     = CMD_SMUL;
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                cmd.op = CMD_SWR;
                if (step_reg == 4'd7)
                begin
                    step_next  = 4'd0;
                    state_next = ST_TRI;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_SMUL;
                end
            end
            ST_TRI:  begin cmd.op = CMD_TRI; state_next = ST_A1; end
            ST_A1:   begin cmd.op = CMD_A1;  state_next = ST_A2; end
            ST_A2:   begin cmd.op = CMD_A2;  state_next = ST_A3; end
            ST_A3:   begin cmd.op = CMD_A3;  state_next = ST_TCHK; end
            ST_TCHK:
            begin
                if (status.area_skip || status.box_empty)
                begin
                    tri_next   = 1'b1;
                    state_next = tri_reg ? ST_FIN : ST_TRI;
                end
                else
                    state_next = ST_PD;
            end
            ST_PD:   begin cmd.op = CMD_PD; state_next = ST_E1; end
            ST_E1:   begin cmd.op = CMD_E1; state_next = ST_E2; end
            ST_E2:   begin cmd.op = CMD_E2; state_next = ST_E3; end
            ST_E3:   begin cmd.op = CMD_E3; state_next = ST_E4; end
            ST_E4:   begin cmd.op = CMD_E4; state_next = ST_E5; end
            ST_E5:   begin cmd.op = CMD_E5; state_next = ST_E6; end
            ST_E6:   begin cmd.op = CMD_E6; state_next = ST_CHK; end
            ST_CHK:  state_next = status.covered ? ST_N1 : ST_NEXT;
            ST_N1:   begin cmd.op = CMD_N1; state_next = ST_N2; end
            ST_N2:   begin cmd.op = CMD_N2; state_next = ST_N3; end
            ST_N3:   begin cmd.op = CMD_N3; state_next = ST_N4; end
            ST_N4:   begin cmd.op = CMD_N4; state_next = ST_DINIT; end
            ST_DINIT:
            begin
                cmd.op     = CMD_DINIT;
                step_next  = 4'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op    = CMD_DIV;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                    state_next = ST_WR;
            end
            ST_WR:   begin cmd.op = CMD_WR; state_next = ST_NEXT; end
            ST_NEXT:
            begin
                cmd.op = CMD_NEXT;
                if (status.last_x && status.last_y)
                begin
                    tri_next   = 1'b1;
                    state_next = tri_reg ? ST_FIN : ST_TRI;
                end
                else
                    state_next = ST_PD;
            end
            ST_READ:  begin cmd.op = CMD_READ;  state_next = ST_FIN; end
            ST_CLEAR: begin cmd.op = CMD_CLEAR; state_next = ST_FIN; end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = CMD_FIN;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_FIN) |-> !status.out_busy)
        else $error("result loaded into a busy output register");

    // An accepted transaction always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // Nothing but the clearing sweep runs until the store is initialized.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> (cmd.op == CMD_CLR && !in_ready))
        else $error("activity during clearing sweep");

endmodule

// ===== rtl/core/dtw_dp.sv =====
// Datapath for the depth triangle warp block: configuration, corner warp, edge
// functions, shared multiplier, restoring divider and the depth store. Depends on dtw_pkg.
`timescale 1ns / 1ps

module dtw_dp
    import dtw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_pos_x,
    input  logic [7:0]  in_pos_y,
    input  logic [63:0] in_depths,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [15:0] out_read_depth,
    output logic [12:0] out_pixels_raised
);

    function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic signed [VW-1:0] c);
        logic signed [VW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic signed [VW-1:0] c);
        logic signed [VW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Configuration.
    logic [6:0]  frame_width_reg, frame_height_reg;
    logic [15:0] disp_x_reg, disp_y_reg, area_limit_reg;
    logic [6:0]  eff_w, eff_h;

    // Item registers.
    logic [1:0]           op_reg;
    logic signed [7:0]    px_reg, py_reg;
    logic signed [15:0]   dep_reg [4];

    // Geometry.
    logic signed [VW-1:0] vx_reg [4];
    logic signed [VW-1:0] vy_reg [4];
    logic signed [DW-1:0] d13x_reg, d23x_reg, d13y_reg, d23y_reg, d03x_reg, d03y_reg;
    logic signed [BW-1:0] sx_reg, ex_reg, sy_reg, ey_reg, pxc_reg, pyc_reg;
    logic signed [ACCW-1:0] area_reg, al_reg, be_reg, ga_reg, acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [RW-1:0]        rem_reg;
    logic [DSW-1:0]       dsh_reg;
    logic [15:0]          q_reg;
    logic [12:0]          cnt_reg;

    // Store.
    logic [15:0]          mem [STORE_N];
    logic [15:0]          rd_reg;
    logic [AW-1:0]        clr_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [15:0]          mem_wdata;

    // Output register.
    logic                 out_valid_reg;
    logic [15:0]          out_depth_reg;
    logic [12:0]          out_raised_reg;

    // Combinational helpers.
    logic signed [33:0]   rnd;
    logic signed [VW-1:0] corner_pos, corner_new;
    logic [1:0]           corner;
    logic signed [VW-1:0] v1x, v1y;
    logic signed [15:0]   d1;
    logic signed [VW:0]   minx, miny, maxx, maxy;
    logic signed [BW-1:0] fl_x, fl_y, cl_x, cl_y, lim_x, lim_y;
    logic signed [ACCW-1:0] ga_raw, mag, two_num, rem_init;
    logic [ACCW-1:0]      lim_a;
    logic signed [8:0]    ipx, ipy;
    logic                 item_in;
    logic [AW-1:0]        addr_item, addr_cur;
    logic                 ge;
    logic [15:0]          val;
    logic                 raise;

    assign eff_w = (frame_width_reg > 7'(FRAME_W)) ? 7'(FRAME_W) : frame_width_reg;
    assign eff_h = (frame_height_reg > 7'(FRAME_H)) ? 7'(FRAME_H) : frame_height_reg;

    // Corner warp: shift = floor((disp * depth + 2048) / 4096).
    assign rnd        = $signed(prod_reg[33:0]) + 34'sd2048;
    assign corner     = cmd.idx[2:1];
    assign corner_pos = cmd.idx[0] ? {{(VW-16){py_reg[7]}}, py_reg, 8'd0}
                                   : {{(VW-16){px_reg[7]}}, px_reg, 8'd0};
    assign corner_new = corner_pos + rnd[12+VW-1:12]
                      + ((cmd.idx[0] ? corner[1] : corner[0]) ? VW'(256) : VW'(0));

    assign v1x = cmd.tri_sel ? vx_reg[3] : vx_reg[0];
    assign v1y = cmd.tri_sel ? vy_reg[3] : vy_reg[0];
    assign d1  = cmd.tri_sel ? dep_reg[3] : dep_reg[0];

    assign minx  = (VW+1)'(min3(v1x, vx_reg[1], vx_reg[2]));
    assign miny  = (VW+1)'(min3(v1y, vy_reg[1], vy_reg[2]));
    assign maxx  = (VW+1)'(max3(v1x, vx_reg[1], vx_reg[2])) + (VW+1)'(255);
    assign maxy  = (VW+1)'(max3(v1y, vy_reg[1], vy_reg[2])) + (VW+1)'(255);
    assign fl_x  = BW'(minx >>> 8);
    assign fl_y  = BW'(miny >>> 8);
    assign cl_x  = BW'(maxx >>> 8);
    assign cl_y  = BW'(maxy >>> 8);
    assign lim_x = $signed(BW'(eff_w)) + BW'(EDGE);
    assign lim_y = $signed(BW'(eff_h)) + BW'(EDGE);

    assign mag      = area_reg[ACCW-1] ? -area_reg : area_reg;
    assign lim_a    = ACCW'({area_limit_reg, 8'd0});
    assign ga_raw   = area_reg - al_reg - be_reg;
    assign two_num  = acc_reg <<< 1;
    assign rem_init = two_num + mag + (mag <<< 16);

    // Item pixel range check for read and clear.
    assign ipx     = {px_reg[7], px_reg};
    assign ipy     = {py_reg[7], py_reg};
    assign item_in = (ipx >= -9'sd4) && (ipx < $signed({2'b00, eff_w}) + 9'sd4)
                  && (ipy >= -9'sd4) && (ipy < $signed({2'b00, eff_h}) + 9'sd4);
    assign addr_item = AW'(ipy + 9'sd4) * AW'(STORE_W) + AW'(ipx + 9'sd4);
    assign addr_cur  = AW'(pyc_reg + BW'(EDGE)) * AW'(STORE_W) + AW'(pxc_reg + BW'(EDGE));

    assign ge    = (rem_reg >= RW'(dsh_reg));
    assign val   = {~q_reg[15], q_reg[14:0]};
    assign raise = ($signed(val) > $signed(rd_reg));

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            CMD_SMUL:
            begin
                mul_a = MW'($signed(cmd.idx[0] ? disp_y_reg : disp_x_reg));
                mul_b = MW'(dep_reg[cmd.idx[2:1]]);
            end
            CMD_A1:  begin mul_a = MW'(d23y_reg); mul_b = MW'(d13x_reg); end
            CMD_A2:  begin mul_a = MW'(d23x_reg); mul_b = MW'(d13y_reg); end
            CMD_E1:  begin mul_a = MW'(d23y_reg); mul_b = MW'(d03x_reg); end
            CMD_E2:  begin mul_a = MW'(d23x_reg); mul_b = MW'(d03y_reg); end
            CMD_E3:  begin mul_a = MW'(d13x_reg); mul_b = MW'(d03y_reg); end
            CMD_E4:  begin mul_a = MW'(d13y_reg); mul_b = MW'(d03x_reg); end
            // Weights of a covered pixel are below the area limit, so they fit.
            CMD_N1:  begin mul_a = MW'(al_reg); mul_b = MW'(d1); end
            CMD_N2:  begin mul_a = MW'(be_reg); mul_b = MW'(dep_reg[1]); end
            CMD_N3:  begin mul_a = MW'(ga_reg); mul_b = MW'(dep_reg[2]); end
            default: ;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_cur;
        mem_wdata = EMPTY_DEPTH;
        case (cmd.op)
            CMD_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            CMD_CLEAR:
            begin
                mem_we   = item_in;
                mem_addr = addr_item;
            end
            CMD_READ: mem_addr = addr_item;
            CMD_WR:
            begin
                mem_we    = raise;
                mem_wdata = val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.op == CMD_READ || cmd.op == CMD_E6)
            rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 7'd64;
            frame_height_reg <= 7'd64;
            disp_x_reg       <= 16'd0;
            disp_y_reg       <= 16'd0;
            area_limit_reg   <= 16'd512;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[6:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[6:0];
                    CFG_DISP_X:       disp_x_reg       <= cfg_data;
                    CFG_DISP_Y:       disp_y_reg       <= cfg_data;
                    CFG_AREA_LIMIT:   area_limit_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == CMD_CLR)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.op == CMD_FIN)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            CMD_LOAD:
            begin
                op_reg     <= in_opcode;
                px_reg     <= in_pos_x;
                py_reg     <= in_pos_y;
                dep_reg[0] <= in_depths[15:0];
                dep_reg[1] <= in_depths[31:16];
                dep_reg[2] <= in_depths[47:32];
                dep_reg[3] <= in_depths[63:48];
                cnt_reg    <= '0;
            end
            CMD_SWR:
            begin
                if (cmd.idx[0])
                    vy_reg[corner] <= corner_new;
                else
                    vx_reg[corner] <= corner_new;
            end
            CMD_TRI:
            begin
                d13x_reg <= DW'(v1x) - DW'(vx_reg[2]);
                d23x_reg <= DW'(vx_reg[1]) - DW'(vx_reg[2]);
                d13y_reg <= DW'(v1y) - DW'(vy_reg[2]);
                d23y_reg <= DW'(vy_reg[1]) - DW'(vy_reg[2]);
                sx_reg   <= (fl_x < -BW'(EDGE)) ? -BW'(EDGE) : fl_x;
                sy_reg   <= (fl_y < -BW'(EDGE)) ? -BW'(EDGE) : fl_y;
                ex_reg   <= (cl_x > lim_x) ? lim_x : cl_x;
                ey_reg   <= (cl_y > lim_y) ? lim_y : cl_y;
                pxc_reg  <= (fl_x < -BW'(EDGE)) ? -BW'(EDGE) : fl_x;
                pyc_reg  <= (fl_y < -BW'(EDGE)) ? -BW'(EDGE) : fl_y;
            end
            CMD_A2, CMD_E2, CMD_N2: acc_reg <= prod_reg[ACCW-1:0];
            CMD_A3: area_reg <= acc_reg - prod_reg[ACCW-1:0];
            CMD_PD:
            begin
                d03x_reg <= $signed({pxc_reg, 8'd0}) - DW'(vx_reg[2]);
                d03y_reg <= $signed({pyc_reg, 8'd0}) - DW'(vy_reg[2]);
            end
            CMD_E3: al_reg <= acc_reg - prod_reg[ACCW-1:0];
            CMD_E4: acc_reg <= prod_reg[ACCW-1:0];
            CMD_E5: be_reg <= acc_reg - prod_reg[ACCW-1:0];
            CMD_E6:
            begin
                // The lower-right triangle is drawn with reversed orientation.
                if (cmd.tri_sel)
                begin
                    al_reg <= -al_reg;
                    be_reg <= -be_reg;
                    ga_reg <= -ga_raw;
                end
                else
                    ga_reg <= ga_raw;
            end
            CMD_N3, CMD_N4: acc_reg <= acc_reg + prod_reg[ACCW-1:0];
            CMD_DINIT:
            begin
                // Offset the dividend so the quotient lands in 0..65535.
                rem_reg <= rem_init[RW-1:0];
                dsh_reg <= DSW'(mag[ACCW-1:0] << 16);
                q_reg   <= '0;
            end
            CMD_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - RW'(dsh_reg);
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= {q_reg[14:0], ge};
            end
            CMD_WR:
            begin
                if (raise && cnt_reg != RAISED_MAX)
                    cnt_reg <= cnt_reg + 13'd1;
            end
            CMD_NEXT:
            begin
                if (pxc_reg + BW'(1) >= ex_reg)
                begin
                    pxc_reg <= sx_reg;
                    pyc_reg <= pyc_reg + BW'(1);
                end
                else
                    pxc_reg <= pxc_reg + BW'(1);
            end
            CMD_FIN:
            begin
                out_depth_reg  <= (op_reg == OP_READ) ? (item_in ? rd_reg : EMPTY_DEPTH)
                                                      : 16'd0;
                out_raised_reg <= (op_reg == OP_SPLAT) ? cnt_reg : 13'd0;
            end
            default: ;
        endcase
    end

    assign status.opcode    = in_opcode;
    assign status.area_skip = (area_reg == '0) || ($unsigned(mag) >= lim_a)
                           || (cmd.tri_sel ? !area_reg[ACCW-1] : area_reg[ACCW-1]);
    assign status.box_empty = (sx_reg >= ex_reg) || (sy_reg >= ey_reg);
    assign status.covered   = !al_reg[ACCW-1] && !be_reg[ACCW-1] && !ga_reg[ACCW-1];
    assign status.last_x    = (pxc_reg + BW'(1) >= ex_reg);
    assign status.last_y    = (pyc_reg + BW'(1) >= ey_reg);
    assign status.clr_last  = (clr_reg == AW'(STORE_N - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid         = out_valid_reg;
    assign out_read_depth    = out_depth_reg;
    assign out_pixels_raised = out_raised_reg;

endmodule

// ===== rtl/core/depth_triangle_warp_max.sv =====
// Top level of the depth triangle warp block: stream ports, controller and datapath.
// Depends on dtw_pkg, dtw_ctrl and dtw_dp.
`timescale 1ns / 1ps

// Forward-warps grid cells of a depth map into a 72 x 72 max-depth store
// (64 x 64 frame plus a 4-pixel margin). After reset the store is swept to
// the empty marker, one entry per cycle, over all 5184 entries; s_tready
// stays low meanwhile. Items are processed one at a time by a single shared
// multiplier and a one-bit-per-cycle divider. Read and clear items access
// the store once before the result is loaded. A splat warps its corners,
// then, per triangle, runs its setup and visits every pixel of its clipped
// bounding box; a covered pixel also runs the 16-step depth division before
// its store write, and the result is loaded last. The next item is accepted
// while a finished result still waits on m_tdata; a further result waits
// until that one is taken.
module depth_triangle_warp_max
    import dtw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[7:0], pos_y[15:8], depth_ul[31:16], depth_ur[47:32],
    // depth_ll[63:48], depth_lr[79:64]
    input  logic [79:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_depth[15:0], pixels_raised[28:16], zero[31:29]
    output logic [31:0] m_tdata
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [15:0] read_depth;
    logic [12:0] pixels_raised;

    dtw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dtw_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_opcode         (s_tuser),
        .in_pos_x          (s_tdata[7:0]),
        .in_pos_y          (s_tdata[15:8]),
        .in_depths         (s_tdata[79:16]),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_read_depth    (read_depth),
        .out_pixels_raised (pixels_raised)
    );

    assign m_tdata = {3'b000, pixels_raised, read_depth};

endmodule
